[sv/assert_macros.svh]
// Assertion macros used by the decoder RTL (htd_ctrl).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every rising clock edge out of reset.
`define HTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define HTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/htd_pkg.sv]
// Package for the prefix-code tree decoder: field widths, codes, defaults.
// No dependencies.
`default_nettype none

package htd_pkg;

  localparam int unsigned NODE_COUNT_DEF   = 512;
  localparam int unsigned MAX_CODE_LEN_DEF = 16;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned BITS_W   = 16;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SYM_W-1:0] NO_SYMBOL = 8'hFF;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DECODED = 2'd0,
    ST_LOADED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

endpackage

`default_nettype wire

[sv/htd_in_if.sv]
// Input channel of the decoder: valid/ready plus one load or decode word.
// Depends on htd_pkg for field widths.
`default_nettype none

interface htd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [htd_pkg::SYM_W-1:0]     symbol;
  logic [htd_pkg::BITS_W-1:0]    code_bits;
  logic [htd_pkg::LEN_W-1:0]     code_length;
  logic                          data_bit;

  modport source (output valid, func, symbol, code_bits, code_length, data_bit,
                  input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, data_bit,
                  output ready);
endinterface

`default_nettype wire

[sv/htd_out_if.sv]
// Result channel of the decoder: valid/ready plus symbol and status.
// Depends on htd_pkg for field widths.
`default_nettype none

interface htd_out_if;
  logic                          valid;
  logic                          ready;
  logic [htd_pkg::SYM_W-1:0]     symbol_out;
  logic [htd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, symbol_out, status, input ready);
  modport sink   (input valid, symbol_out, status, output ready);
endinterface

`default_nettype wire

[sv/htd_node_mem.sv]
// Node table storage: one write port, one read port, registered read data.
// Standalone; sized by its parameters.
`default_nettype none

module htd_node_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 26
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/htd_ctrl.sv]
// Sequencer for tree loads and bit decodes; root node and counters in flops.
// Depends on htd_pkg, htd_in_if, htd_out_if, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module htd_ctrl #(
  parameter int unsigned NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
  localparam int unsigned IDX_W       = $clog2(NODE_COUNT),
  localparam int unsigned NODE_W      = 2 * IDX_W + htd_pkg::SYM_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  htd_in_if.sink                 in_i,
  htd_out_if.source              out_o,
  output logic                   mem_we_o,
  output logic [IDX_W-1:0]       mem_waddr_o,
  output logic [NODE_W-1:0]      mem_wdata_o,
  output logic                   mem_re_o,
  output logic [IDX_W-1:0]       mem_raddr_o,
  input  wire logic [NODE_W-1:0] mem_rdata_i
);

  localparam int unsigned CNT_W = $clog2(NODE_COUNT + 1);
  localparam int unsigned LEN_W = htd_pkg::LEN_W;

  typedef struct packed {
    logic [IDX_W-1:0]          left;
    logic [IDX_W-1:0]          right;
    logic [htd_pkg::SYM_W-1:0] sym;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_LD_STEP = 5'b00010,
    S_LD_WAIT = 5'b00100,
    S_DEC_CUR = 5'b01000,
    S_DEC_NXT = 5'b10000
  } state_e;

  localparam node_t NODE_CLEAR = '{left: '0, right: '0, sym: htd_pkg::NO_SYMBOL};

  state_e                     state_q, state_d;
  logic [htd_pkg::SYM_W-1:0]  sym_q, sym_d;
  logic [htd_pkg::BITS_W-1:0] bits_q, bits_d;
  logic [LEN_W-1:0]           rem_q, rem_d;
  logic                       dbit_q, dbit_d;
  logic [IDX_W-1:0]           node_q, node_d;
  node_t                      entry_q, entry_d;
  node_t                      root_q, root_d;
  logic [CNT_W-1:0]           used_q, used_d;
  logic [IDX_W-1:0]           cur_q, cur_d;
  logic                       out_valid_q, out_valid_d;
  logic [htd_pkg::SYM_W-1:0]  out_sym_q, out_sym_d;
  htd_pkg::status_e           out_status_q, out_status_d;

  logic                       out_free;
  logic                       accept;
  logic                       set_out;
  logic [htd_pkg::SYM_W-1:0]  res_sym;
  htd_pkg::status_e           res_status;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_idx;
  node_t                      wr_val;
  logic [LEN_W-1:0]           pos;
  logic                       ld_bit;
  logic [IDX_W-1:0]           ld_slot;
  logic                       alloc;
  node_t                      parent_upd;
  node_t                      cur_entry;
  logic [IDX_W-1:0]           dec_child;
  node_t                      rd_entry;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept = in_i.valid && in_i.ready;
  assign rd_entry = node_t'(mem_rdata_i);

  // load walk: bit taken this step, positions 16 and up read as left
  assign pos     = rem_q - LEN_W'(1);
  assign ld_bit  = pos[LEN_W-1] ? 1'b0 : bits_q[pos[LEN_W-2:0]];
  assign ld_slot = ld_bit ? entry_q.right : entry_q.left;

  always_comb begin
    parent_upd = entry_q;
    if (ld_bit) begin
      parent_upd.right = used_q[IDX_W-1:0];
    end else begin
      parent_upd.left = used_q[IDX_W-1:0];
    end
  end

  assign cur_entry = (cur_q == '0) ? root_q : rd_entry;
  assign dec_child = dbit_q ? cur_entry.right : cur_entry.left;

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    bits_d      = bits_q;
    rem_d       = rem_q;
    dbit_d      = dbit_q;
    node_d      = node_q;
    entry_d     = entry_q;
    used_d      = used_q;
    cur_d       = cur_q;
    set_out     = 1'b0;
    res_sym     = '0;
    res_status  = htd_pkg::ST_LOADED;
    wr_en       = 1'b0;
    wr_idx      = node_q;
    wr_val      = entry_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_q;
    alloc       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sym_d  = in_i.symbol;
          bits_d = in_i.code_bits;
          dbit_d = in_i.data_bit;
          if (32'(in_i.code_length) > MAX_CODE_LEN) begin
            rem_d = LEN_W'(MAX_CODE_LEN);
          end else begin
            rem_d = in_i.code_length;
          end
          if (in_i.func == htd_pkg::FUNC_LOAD) begin
            node_d  = '0;
            entry_d = root_q;
            state_d = S_LD_STEP;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = cur_q;
            state_d     = S_DEC_CUR;
          end
        end
      end

      S_LD_STEP: begin
        if (rem_q == '0) begin
          if (out_free) begin
            wr_en      = 1'b1;
            wr_val.sym = sym_q;
            set_out    = 1'b1;
            res_status = htd_pkg::ST_LOADED;
            state_d    = S_IDLE;
          end
        end else if (ld_slot != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ld_slot;
          node_d      = ld_slot;
          rem_d       = rem_q - LEN_W'(1);
          state_d     = S_LD_WAIT;
        end else if (used_q == CNT_W'(NODE_COUNT)) begin
          // flush the working node: it may be freshly allocated
          if (out_free) begin
            wr_en      = 1'b1;
            set_out    = 1'b1;
            res_status = htd_pkg::ST_FULL;
            state_d    = S_IDLE;
          end
        end else begin
          alloc   = 1'b1;
          wr_en   = 1'b1;
          wr_val  = parent_upd;
          entry_d = NODE_CLEAR;
          node_d  = used_q[IDX_W-1:0];
          used_d  = used_q + CNT_W'(1);
          rem_d   = rem_q - LEN_W'(1);
        end
      end

      S_LD_WAIT: begin
        entry_d = rd_entry;
        state_d = S_LD_STEP;
      end

      S_DEC_CUR: begin
        if (dec_child == '0) begin
          if (out_free) begin
            cur_d      = '0;
            set_out    = 1'b1;
            res_status = htd_pkg::ST_INVALID;
            state_d    = S_IDLE;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = dec_child;
          node_d      = dec_child;
          state_d     = S_DEC_NXT;
        end
      end

      S_DEC_NXT: begin
        if (rd_entry.left == '0 && rd_entry.right == '0) begin
          if (out_free) begin
            cur_d      = '0;
            set_out    = 1'b1;
            res_sym    = rd_entry.sym;
            res_status = htd_pkg::ST_DECODED;
            state_d    = S_IDLE;
          end
        end else begin
          cur_d   = node_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // root lives in flops; every other node in the table
  assign mem_we_o    = wr_en && (wr_idx != '0);
  assign mem_waddr_o = wr_idx;
  assign mem_wdata_o = NODE_W'(wr_val);
  assign root_d      = (wr_en && (wr_idx == '0)) ? wr_val : root_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_status_d = out_status_q;
    if (set_out) begin
      out_valid_d  = 1'b1;
      out_sym_d    = res_sym;
      out_status_d = res_status;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.symbol_out = out_sym_q;
  assign out_o.status     = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= NODE_CLEAR;
      used_q      <= CNT_W'(1);
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      used_q      <= used_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    bits_q       <= bits_d;
    rem_q        <= rem_d;
    dbit_q       <= dbit_d;
    node_q       <= node_d;
    entry_q      <= entry_d;
    out_sym_q    <= out_sym_d;
    out_status_q <= out_status_d;
  end

  `HTD_ASSERT(a_used_range, (used_q != '0) && (used_q <= CNT_W'(NODE_COUNT)), "node count out of range")
  `HTD_ASSERT(a_cur_alloc, CNT_W'(cur_q) < used_q, "decode position not allocated")
  `HTD_ASSERT_IMPL(a_no_root_mem, mem_we_o, mem_waddr_o != '0, "root written to table")
  `HTD_ASSERT_IMPL(a_sym_zero, out_valid_q && (out_status_q != htd_pkg::ST_DECODED), out_sym_q == '0, "nonzero symbol on status")
  `HTD_ASSERT_NEXT(a_alloc_count, alloc, used_q == $past(used_q) + CNT_W'(1), "allocation lost")

endmodule

`default_nettype wire

[sv/huffman_tree_decoder.sv]
// Prefix-code tree decoder: controller plus node table.
// Depends on htd_pkg, htd_in_if, htd_out_if, htd_ctrl, htd_node_mem.
//
// Usage:
//   in_i  carries one word per item: func selects a code load (symbol,
//         code_bits, code_length) or a one-bit decode step (data_bit).
//   out_o carries symbol_out and status: loaded, table full, decoded
//         symbol, or invalid path. Decode steps onto an inner node give no word.
//   Timing: one item in flight; in_i.ready is high while the sequencer idles.
//   A decode accepts the word with a read of the current node, then reads
//   the child, or ends there when the step hits a missing child. A load
//   allocates each new node on its path in place and reads each existing
//   one through a wait state. The word shows the cycle after the last step.
//   Stall: a new item is accepted while a result waits; if out_o.ready stays
//   low the sequencer holds in its final step until the register frees.
//   Reset: the root holds no children and symbol 0xFF, one node is in use,
//   decoding starts at the root. Other entries are written when allocated.
`default_nettype none

module huffman_tree_decoder #(
  parameter int unsigned NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o
);

  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  localparam int unsigned NODE_W = 2 * IDX_W + htd_pkg::SYM_W;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [NODE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [NODE_W-1:0] mem_rdata;

  htd_ctrl #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  htd_node_mem #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_W)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

[tb/sv/huffman_tree_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_decoder: code loads and bit-serial decoding,
// checked against a tree predictor kept in step with every accepted word.
// Depends on htd_pkg, htd_in_if, htd_out_if and the decoder RTL.

module huffman_tree_decoder_tb;

  localparam int unsigned NODES       = htd_pkg::NODE_COUNT_DEF;
  localparam int unsigned MAX_LEN     = htd_pkg::MAX_CODE_LEN_DEF;
  localparam int unsigned SYM_W       = htd_pkg::SYM_W;
  localparam int unsigned BITS_W      = htd_pkg::BITS_W;
  localparam int unsigned LEN_W       = htd_pkg::LEN_W;
  localparam int unsigned IDX_W       = $clog2(NODES);
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SHOW_LIMIT  = 10;

  typedef struct packed {
    htd_pkg::func_e     func;
    logic [SYM_W-1:0]   symbol;
    logic [BITS_W-1:0]  code_bits;
    logic [LEN_W-1:0]   code_length;
    logic               data_bit;
  } code_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    htd_pkg::status_e status;
  } result_t;

  logic clk_i;
  logic rst_ni;

  htd_in_if  in_bus ();
  htd_out_if out_bus ();

  huffman_tree_decoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Predicted tree; child index 0 means no child
  logic [IDX_W-1:0] tree_left  [NODES];
  logic [IDX_W-1:0] tree_right [NODES];
  logic [SYM_W-1:0] tree_sym   [NODES];
  int unsigned      tree_used;
  logic [IDX_W-1:0] walk_node;
  int unsigned      full_hits;

  result_t     status_queue[$];
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned hold_req;
  int unsigned idle_cycles;

  function automatic void tree_reset();
    tree_left[0]  = '0;
    tree_right[0] = '0;
    tree_sym[0]   = htd_pkg::NO_SYMBOL;
    tree_used     = 1;
    walk_node     = '0;
  endfunction

  // Applies one accepted word to the tree; returns 1 when a word is due on out_o.
  function automatic bit tree_step(input code_word_t w, output result_t r);
    int unsigned len;
    int unsigned node;
    int unsigned next;
    bit          b;
    bit          stop;
    bit          got;
    r.symbol = '0;
    r.status = htd_pkg::ST_LOADED;
    got = 1'b1;
    if (w.func == htd_pkg::FUNC_LOAD) begin
      len  = (w.code_length > MAX_LEN) ? MAX_LEN : w.code_length;
      node = 0;
      stop = 1'b0;
      for (int i = 0; i < len && !stop; i++) begin
        b    = w.code_bits[len-1-i];
        next = b ? tree_right[node] : tree_left[node];
        if (next == 0) begin
          if (tree_used >= NODES) begin
            stop = 1'b1;
          end else begin
            next = tree_used;
            tree_left[next]  = '0;
            tree_right[next] = '0;
            tree_sym[next]   = htd_pkg::NO_SYMBOL;
            if (b) tree_right[node] = IDX_W'(next);
            else   tree_left[node]  = IDX_W'(next);
            tree_used++;
          end
        end
        node = next;
      end
      if (stop) begin
        r.status = htd_pkg::ST_FULL;
        full_hits++;
      end else begin
        tree_sym[node] = w.symbol;
      end
    end else begin
      next = w.data_bit ? tree_right[walk_node] : tree_left[walk_node];
      if (next == 0) begin
        walk_node = '0;
        r.status  = htd_pkg::ST_INVALID;
      end else if (tree_left[next] == 0 && tree_right[next] == 0) begin
        walk_node = '0;
        r.symbol  = tree_sym[next];
        r.status  = htd_pkg::ST_DECODED;
      end else begin
        walk_node = IDX_W'(next);
        got = 1'b0;
      end
    end
    return got;
  endfunction

  // Mostly follows existing branches so decodes reach deep into the tree.
  function automatic logic guided_bit();
    logic has_l;
    logic has_r;
    has_l = (tree_left[walk_node] != 0);
    has_r = (tree_right[walk_node] != 0);
    if (has_l && has_r) return 1'($urandom_range(0, 1));
    if (has_l) return ($urandom_range(0, 9) == 0);
    if (has_r) return ($urandom_range(0, 9) != 0);
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic code_word_t make_load(input logic [SYM_W-1:0] sym,
                                           input logic [BITS_W-1:0] bits,
                                           input int unsigned len);
    code_word_t w;
    w.func        = htd_pkg::FUNC_LOAD;
    w.symbol      = sym;
    w.code_bits   = bits;
    w.code_length = LEN_W'(len);
    w.data_bit    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Unused fields carry random noise.
  function automatic code_word_t make_decode(input logic dbit);
    code_word_t w;
    w.func        = htd_pkg::FUNC_DECODE;
    w.symbol      = SYM_W'($urandom);
    w.code_bits   = BITS_W'($urandom);
    w.code_length = LEN_W'($urandom);
    w.data_bit    = dbit;
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < SHOW_LIMIT) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_word(input code_word_t w);
    int unsigned gap;
    result_t     r;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= w.func;
    in_bus.symbol      <= w.symbol;
    in_bus.code_bits   <= w.code_bits;
    in_bus.code_length <= w.code_length;
    in_bus.data_bit    <= w.data_bit;
    do @(posedge clk_i); while (!in_bus.ready);
    if (tree_step(w, r)) status_queue = {status_queue, r};
  endtask

  task automatic test_directed();
    send_word(make_decode(1'b0));                   // empty tree: invalid
    send_word(make_decode(1'b1));
    send_word(make_load(8'h5A, 16'h0000, 0));       // symbol at the root
    send_word(make_load(8'h00, 16'h0000, 1));       // "0"
    send_word(make_load(8'hFF, 16'h0002, 2));       // "10"
    send_word(make_decode(1'b0));
    send_word(make_decode(1'b1));                   // inner step, no word
    send_word(make_decode(1'b0));
    send_word(make_decode(1'b1));
    send_word(make_decode(1'b1));                   // "11" missing
    send_word(make_load(8'h81, 16'hFFFF, 17));      // clipped to 16 bits
    send_word(make_load(8'h42, 16'h0007, 3));       // symbol on an inner node
    send_word(make_decode(1'b1));
    send_word(make_decode(1'b0));
    send_word(make_decode(1'b1));
    send_word(make_decode(1'b1));
    send_word(make_decode(1'b0));                   // "110" missing mid-path
    send_word(make_load(8'h7E, 16'h8000, 31));      // extends through leaf "10"
  endtask

  task automatic test_random_small();
    int unsigned pick;
    for (int n = 0; n < 500; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 7)
        send_word(make_load(SYM_W'($urandom), BITS_W'($urandom),
                            (pick == 0) ? 0 : $urandom_range(1, 6)));
      else if (pick < 90)
        send_word(make_decode(guided_bit()));
      else
        send_word(make_decode(1'($urandom_range(0, 1))));
    end
  endtask

  // Output held off while input keeps coming, so the block backs up.
  task automatic test_stalled_output();
    hold_req = 300;
    for (int n = 0; n < 16; n++) begin
      if (n % 7 == 3)
        send_word(make_load(SYM_W'($urandom), BITS_W'($urandom), $urandom_range(1, 5)));
      else
        send_word(make_decode(guided_bit()));
    end
  endtask

  task automatic test_table_full();
    int unsigned len;
    for (int n = 0; n < 200 && full_hits < 6; n++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(12, 16);
      send_word(make_load(SYM_W'($urandom), BITS_W'($urandom), len));
      repeat ($urandom_range(0, 3)) send_word(make_decode(guided_bit()));
    end
    send_word(make_load(SYM_W'($urandom), BITS_W'($urandom), 0));
  endtask

  task automatic test_random_full();
    int unsigned pick;
    for (int n = 0; n < 350; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        send_word(make_load(SYM_W'($urandom), BITS_W'($urandom), $urandom_range(0, 16)));
      else if (pick < 88)
        send_word(make_decode(guided_bit()));
      else
        send_word(make_decode(1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random ready modes, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (status_queue.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: symbol %02h status %0d",
                                out_bus.symbol_out, out_bus.status));
      end else begin
        want = status_queue.pop_front();
        if (out_bus.symbol_out !== want.symbol || out_bus.status !== want.status)
          flag_mismatch($sformatf("symbol %02h status %0d, expected symbol %02h status %0d",
                                  out_bus.symbol_out, out_bus.status,
                                  want.symbol, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("huffman_tree_decoder_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = htd_pkg::FUNC_LOAD;
    in_bus.symbol      = '0;
    in_bus.code_bits   = '0;
    in_bus.code_length = '0;
    in_bus.data_bit    = 1'b0;
    mismatches  = 0;
    burst_left  = 0;
    hold_req    = 0;
    full_hits   = 0;
    tree_reset();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_small();
    test_stalled_output();
    test_table_full();
    test_random_full();

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("huffman_tree_decoder_tb: clean");
    end else begin
      $display("huffman_tree_decoder_tb: errors");
    end
    $finish;
  end

endmodule
